### hdl/spb_pkg.sv
// Shared types, constants and helper functions for the sprite blitter.
// No dependencies; every other file imports this package.
`default_nettype none

package spb_pkg;

    localparam int SCREEN_WIDTH    = 128;
    localparam int SCREEN_HEIGHT   = 128;
    localparam int MAX_SPRITE_SIDE = 255;

    // Field widths fixed by the interface
    localparam int POS_W   = 13;
    localparam int SIDE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int COORD_W = 7;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Lowest origin kept; anything below is fully off screen anyway
    localparam logic signed [POS_W:0] ORIGIN_MIN = -(POS_W + 1)'(4096);

    typedef struct packed {
        logic               on_screen;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               done;
    } t_blit_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // Zero size reads as one, oversize clamps
    function automatic logic [SIDE_W-1:0] fix_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        r = s;
        if (r == '0) r = SIDE_W'(1);
        if (SIDE_W'(MAX_SPRITE_SIDE) < r) r = SIDE_W'(MAX_SPRITE_SIDE);
        return r;
    endfunction

    // Top-left corner: centre - ceil(side/2), saturated low
    function automatic logic signed [POS_W-1:0] corner(
        input logic signed [POS_W-1:0] c,
        input logic [SIDE_W-1:0]       side
    );
        logic [SIDE_W:0]         half;
        logic signed [POS_W:0]   o;
        half = ({1'b0, side} + (SIDE_W + 1)'(1)) >> 1;
        o    = {c[POS_W-1], c} - $signed((POS_W + 1)'(half));
        if (o < ORIGIN_MIN) o = ORIGIN_MIN;
        return o[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/spb_front.sv
// Front end: accepts pixels, tracks sprite position, classifies on-screen.
// Depends on spb_pkg.
`default_nettype none

module spb_front import spb_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [POS_W-1:0]   i_centre_x,
    input  wire logic signed [POS_W-1:0]   i_centre_y,
    input  wire logic [SIDE_W-1:0]         i_sprite_width,
    input  wire logic [SIDE_W-1:0]         i_sprite_height,
    input  wire logic [COLOR_W-1:0]        i_pixel_color,
    input  wire t_fifo_status              i_q_status,
    output logic                           o_push,
    output t_blit_item                     o_item
);

    logic [SIDE_W-1:0]       r_col, n_col;
    logic [SIDE_W-1:0]       r_row, n_row;
    logic signed [POS_W-1:0] r_org_x, r_org_y;
    logic [SIDE_W-1:0]       r_width, r_height;

    logic                    first;
    logic [SIDE_W-1:0]       eff_w, eff_h;
    logic signed [POS_W-1:0] org_x, org_y;
    logic signed [POS_W:0]   x, y;
    logic                    col_last, row_last;

    assign first = (r_col == '0) && (r_row == '0);
    assign eff_w = first ? fix_side(i_sprite_width)  : r_width;
    assign eff_h = first ? fix_side(i_sprite_height) : r_height;
    assign org_x = first ? corner(i_centre_x, eff_w) : r_org_x;
    assign org_y = first ? corner(i_centre_y, eff_h) : r_org_y;

    assign x = {org_x[POS_W-1], org_x} + $signed({(POS_W + 1 - SIDE_W)'(0), r_col});
    assign y = {org_y[POS_W-1], org_y} + $signed({(POS_W + 1 - SIDE_W)'(0), r_row});

    assign col_last = ({1'b0, r_col} + (SIDE_W + 1)'(1)) >= {1'b0, eff_w};
    assign row_last = ({1'b0, r_row} + (SIDE_W + 1)'(1)) >= {1'b0, eff_h};

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        o_item.on_screen = !x[POS_W] && (x[POS_W-1:0] < POS_W'(SCREEN_WIDTH)) &&
                           !y[POS_W] && (y[POS_W-1:0] < POS_W'(SCREEN_HEIGHT));
        o_item.x         = x[COORD_W-1:0];
        o_item.y         = y[COORD_W-1:0];
        o_item.color     = i_pixel_color;
        o_item.done      = col_last && row_last;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + SIDE_W'(1);
        end else begin
            n_col = r_col + SIDE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
            if (first) begin
                r_width  <= eff_w;
                r_height <= eff_h;
                r_org_x  <= org_x;
                r_org_y  <= org_y;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/spb_fifo.sv
// Short queue of classified pixels between front and back end.
// Depends on spb_pkg.
`default_nettype none

module spb_fifo import spb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_blit_item i_item,
    input  wire logic       i_pop,
    output t_blit_item      o_item,
    output t_fifo_status    o_status
);

    t_blit_item        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_CW-1:0]   r_cnt;

    assign o_item          = r_mem[r_rd];
    assign o_status.full   = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_status.empty  = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_AW'(1);
            if (i_pop)  r_rd <= r_rd + Q_AW'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/spb_back.sv
// Back end: applies the transparent key and drives the output register.
// Depends on spb_pkg.
`default_nettype none

module spb_back import spb_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_key_we,
    input  wire logic [COLOR_W-1:0]  i_key,
    input  wire t_blit_item          i_item,
    input  wire t_fifo_status        i_q_status,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_write_enable,
    output logic [COORD_W-1:0]       o_screen_x,
    output logic [COORD_W-1:0]       o_screen_y,
    output logic [COLOR_W-1:0]       o_write_color,
    output logic                     o_sprite_done
);

    logic [COLOR_W-1:0] r_key;
    logic               r_valid;
    logic               r_en;
    logic [COORD_W-1:0] r_x, r_y;
    logic [COLOR_W-1:0] r_color;
    logic               r_done;
    logic               load;
    logic               en;

    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !i_q_status.empty;
    assign en    = i_item.on_screen && (i_item.color != r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_key_we) r_key <= i_key;
            if (load)     r_valid <= !i_q_status.empty;
        end
    end

    // disabled writes carry zero fields
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_en    <= en;
            r_x     <= en ? i_item.x     : '0;
            r_y     <= en ? i_item.y     : '0;
            r_color <= en ? i_item.color : '0;
            r_done  <= i_item.done;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_write_enable = r_en;
    assign o_screen_x     = r_x;
    assign o_screen_y     = r_y;
    assign o_write_color  = r_color;
    assign o_sprite_done  = r_done;

endmodule

`default_nettype wire

### hdl/sprite_blit_clip_core.sv
// Sprite blitter with colour key and screen clipping, top level.
// Throughput: one pixel per clock, sustained while i_out_stall is low; front and back stall independently.
// Path: an accepted pixel is written into the queue, then loaded into the
// output register that drives the outputs.
// Reset (synchronous, i_rst_n low): counters, latched sprite geometry, queue,
// output valid and the transparent key (to 0) are cleared.
`default_nettype none

module sprite_blit_clip_core import spb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration: transparent colour key
    input  wire logic                     i_transparent_key_we,
    input  wire logic [COLOR_W-1:0]       i_transparent_key,
    // pixel input channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [POS_W-1:0]  i_centre_x,
    input  wire logic signed [POS_W-1:0]  i_centre_y,
    input  wire logic [SIDE_W-1:0]        i_sprite_width,
    input  wire logic [SIDE_W-1:0]        i_sprite_height,
    input  wire logic [COLOR_W-1:0]       i_pixel_color,
    // framebuffer write channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_write_enable,
    output logic [COORD_W-1:0]            o_screen_x,
    output logic [COORD_W-1:0]            o_screen_y,
    output logic [COLOR_W-1:0]            o_write_color,
    output logic                          o_sprite_done
);

    // Front end: one transaction per clock unless the queue is full.
    // It latches centre/size on a sprite's first pixel, walks the
    // row-major counters and flags whether the pixel lands on screen.
    logic         push, pop;
    t_blit_item   front_item, q_item;
    t_fifo_status q_status;

    spb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_centre_x      (i_centre_x),
        .i_centre_y      (i_centre_y),
        .i_sprite_width  (i_sprite_width),
        .i_sprite_height (i_sprite_height),
        .i_pixel_color   (i_pixel_color),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_item          (front_item)
    );

    // Two-entry queue decouples input acceptance from output stall.
    spb_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    // Back end: key compare and registered output, refilled from the queue whenever
    // it holds a pixel and the register is empty or the downstream side takes a transaction.
    spb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_we       (i_transparent_key_we),
        .i_key          (i_transparent_key),
        .i_item         (q_item),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_write_enable (o_write_enable),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y),
        .o_write_color  (o_write_color),
        .o_sprite_done  (o_sprite_done)
    );

`ifndef NO_ASSERTIONS
    // a disabled write must carry all-zero address and colour
    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |->
            (o_screen_x == '0 && o_screen_y == '0 && o_write_color == '0))
        else $error("disabled write carries nonzero fields");

    // an accepted pixel is held in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !q_status.empty)
        else $error("accepted pixel lost before queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop)
        else $error("queue underflow");
`endif

endmodule

`default_nettype wire
